>>> src/ssr_pkg.sv
package ssr_pkg;

    localparam int MAX_PATTERN_DEFAULT   = 8;
    localparam int POSITION_BITS_DEFAULT = 32;

    localparam int DATA_DEPTH   = 8;
    localparam int DATA_IDX_W   = 3;
    localparam int DATA_CNT_W   = 4;
    localparam int RES_CNT_W    = 4;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 64;
    localparam int LEN_W        = 4;
    localparam int MATCH_POS_W  = 32;

    localparam logic [7:0] SPACE_CHAR = 8'h20;

    typedef enum logic [1:0] {
        MODE_REPLACE_ALL   = 2'd0,
        MODE_REPLACE_FIRST = 2'd1,
        MODE_FIND          = 2'd2,
        MODE_SPLIT         = 2'd3
    } mode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MODE        = 3'd0,
        REG_PATTERN     = 3'd1,
        REG_PATTERN_LEN = 3'd2,
        REG_REPL        = 3'd3,
        REG_REPL_LEN    = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0] {
        KIND_DATA     = 2'd0,
        KIND_POSITION = 2'd1,
        KIND_MARKER   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        TAIL_NONE     = 2'd0,
        TAIL_POSITION = 2'd1,
        TAIL_MARKER   = 2'd2
    } tail_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_string;
    } in_req_t;

    typedef struct packed {
        kind_t                  kind;
        logic [7:0]             out_byte;
        logic [MATCH_POS_W-1:0] match_position;
        logic                   run_last;
        logic                   string_done;
    } out_req_t;

endpackage

>>> src/stream_substring_replace_unit.sv
// Streaming find-and-replace over a byte string. Each input request is one
// byte, with end_of_string on the last byte of a string. The byte is matched
// against the configured pattern in the cycle it is accepted, and the results
// it causes (data bytes, a match position or a token marker) are loaded into a
// result buffer that drains one result per cycle while m_ready is high. A byte
// with at most one result never stalls the input, so plain text flows at one
// byte per cycle while m_ready is high; a byte with k results (a replacement
// run or an end-of-string flush, up to 9) stalls the input while the buffer
// drains. Write the configuration registers only while no string is in flight.
module stream_substring_replace_unit #(
    parameter int MAX_PATTERN   = ssr_pkg::MAX_PATTERN_DEFAULT,
    parameter int POSITION_BITS = ssr_pkg::POSITION_BITS_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  ssr_pkg::in_req_t                    s_payload,
    output logic                                m_valid,
    input  logic                                m_ready,
    output ssr_pkg::out_req_t                   m_payload,
    input  logic                                cfg_we,
    input  logic [ssr_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [ssr_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import ssr_pkg::*;

    localparam int HOLD_DEPTH = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;
    localparam int CNT_W      = $clog2(MAX_PATTERN + 1);

    // configuration
    mode_t                 mode_reg;
    logic [CFG_DATA_W-1:0] pattern_reg;
    logic [LEN_W-1:0]      plen_cfg_reg;
    logic [CFG_DATA_W-1:0] repl_reg;
    logic [LEN_W-1:0]      rlen_cfg_reg;

    // string state
    logic [7:0]               held_reg [HOLD_DEPTH];
    logic [7:0]               held_next [HOLD_DEPTH];
    logic [CNT_W-1:0]         held_count_reg, held_count_next;
    logic [POSITION_BITS-1:0] byte_pos_reg, byte_pos_next;
    logic                     first_replaced_reg, first_replaced_next;
    logic                     token_open_reg, token_open_next;

    // result buffer
    logic [7:0]             res_data_reg [DATA_DEPTH];
    logic [7:0]             res_data_next [DATA_DEPTH];
    logic [DATA_CNT_W-1:0]  res_ndata_reg, res_ndata_next;
    tail_t                  res_tail_reg, res_tail_next;
    logic [MATCH_POS_W-1:0] res_pos_reg, res_pos_next;
    logic                   res_eos_reg;
    logic [RES_CNT_W-1:0]   res_count_reg, res_count_next;
    logic [RES_CNT_W-1:0]   res_idx_reg;

    logic s_accept;
    logic res_last;

    // per-byte datapath
    logic [7:0]            buf_b [DATA_DEPTH];
    logic [7:0]            pat_b [DATA_DEPTH];
    logic [CNT_W-1:0]      plen;
    logic [CNT_W-1:0]      cnt;
    logic [LEN_W-1:0]      rlen;
    logic                  split_space;
    logic                  passthru;
    logic                  full;
    logic                  cmp_ok;
    logic                  match;
    logic                  mismatch;
    logic                  use_repl;
    logic                  eos;
    logic [POSITION_BITS-1:0] pos_diff;

    assign eos = s_payload.end_of_string;

    always_comb begin
        if (plen_cfg_reg > LEN_W'(MAX_PATTERN)) begin
            plen = CNT_W'(MAX_PATTERN);
        end else begin
            plen = CNT_W'(plen_cfg_reg);
        end
        split_space = (mode_reg == MODE_SPLIT) && (plen == '0);
        if (split_space) begin
            plen = CNT_W'(1);
        end
        rlen = (rlen_cfg_reg > LEN_W'(DATA_DEPTH)) ? LEN_W'(DATA_DEPTH) : rlen_cfg_reg;

        for (int i = 0; i < DATA_DEPTH; i++) begin
            pat_b[i] = pattern_reg[8*i +: 8];
            buf_b[i] = s_payload.in_byte;
        end
        if (split_space) begin
            pat_b[0] = SPACE_CHAR;
        end
        for (int i = 0; i < HOLD_DEPTH; i++) begin
            if (CNT_W'(i) < held_count_reg) begin
                buf_b[i] = held_reg[i];
            end
        end
        cnt = held_count_reg + CNT_W'(1);

        cmp_ok = 1'b1;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if ((CNT_W'(i) < plen) && (buf_b[i] != pat_b[i])) begin
                cmp_ok = 1'b0;
            end
        end

        passthru = (((mode_reg == MODE_REPLACE_ALL) || (mode_reg == MODE_REPLACE_FIRST))
                    && (plen == '0))
                   || ((mode_reg == MODE_REPLACE_FIRST) && first_replaced_reg);
        full     = !passthru && (plen != '0) && (cnt >= plen);
        match    = full && cmp_ok;
        mismatch = full && !cmp_ok;
        use_repl = match && (mode_reg != MODE_FIND) && (mode_reg != MODE_SPLIT);

        // data bytes caused by this byte
        if (passthru) begin
            res_ndata_next = DATA_CNT_W'(cnt);
        end else if (mode_reg == MODE_FIND) begin
            res_ndata_next = '0;
        end else if (match) begin
            res_ndata_next = use_repl ? DATA_CNT_W'(rlen) : '0;
        end else if (mismatch) begin
            res_ndata_next = eos ? DATA_CNT_W'(cnt) : DATA_CNT_W'(1);
        end else if (plen != '0) begin
            res_ndata_next = eos ? DATA_CNT_W'(cnt) : '0;
        end else begin
            res_ndata_next = '0;
        end

        for (int i = 0; i < DATA_DEPTH; i++) begin
            res_data_next[i] = use_repl ? repl_reg[8*i +: 8] : buf_b[i];
        end

        pos_diff     = byte_pos_reg - POSITION_BITS'(plen - CNT_W'(1));
        res_pos_next = MATCH_POS_W'(pos_diff);

        res_tail_next = TAIL_NONE;
        if ((mode_reg == MODE_FIND) && match) begin
            res_tail_next = TAIL_POSITION;
        end else if ((mode_reg == MODE_SPLIT)
                     && (match || (eos && (token_open_reg || (res_ndata_next != '0))))) begin
            res_tail_next = TAIL_MARKER;
        end
        res_count_next = RES_CNT_W'(res_ndata_next)
                         + ((res_tail_next != TAIL_NONE) ? RES_CNT_W'(1) : '0);

        // next string state
        for (int i = 0; i < HOLD_DEPTH; i++) begin
            held_next[i] = mismatch ? buf_b[i+1] : buf_b[i];
        end
        if (eos || passthru || match || (plen == '0)) begin
            held_count_next = '0;
        end else if (mismatch) begin
            held_count_next = cnt - CNT_W'(1);
        end else begin
            held_count_next = cnt;
        end

        byte_pos_next = eos ? '0 : byte_pos_reg + POSITION_BITS'(1);

        first_replaced_next = first_replaced_reg;
        if (eos) begin
            first_replaced_next = 1'b0;
        end else if (match && (mode_reg == MODE_REPLACE_FIRST)) begin
            first_replaced_next = 1'b1;
        end

        token_open_next = token_open_reg;
        if (eos) begin
            token_open_next = 1'b0;
        end else if (mode_reg == MODE_SPLIT) begin
            if (match) begin
                token_open_next = 1'b0;
            end else if (res_ndata_next != '0) begin
                token_open_next = 1'b1;
            end
        end
    end

    // handshake
    assign m_valid  = (res_idx_reg != res_count_reg);
    assign res_last = (res_idx_reg == (res_count_reg - RES_CNT_W'(1)));
    assign s_ready  = aresetn && (!m_valid || (res_last && m_ready));
    assign s_accept = s_valid && s_ready;

    always_comb begin
        m_payload.run_last    = res_last;
        m_payload.string_done = res_last && res_eos_reg;
        if (res_idx_reg < RES_CNT_W'(res_ndata_reg)) begin
            m_payload.kind           = KIND_DATA;
            m_payload.out_byte       = res_data_reg[res_idx_reg[DATA_IDX_W-1:0]];
            m_payload.match_position = '0;
        end else if (res_tail_reg == TAIL_POSITION) begin
            m_payload.kind           = KIND_POSITION;
            m_payload.out_byte       = '0;
            m_payload.match_position = res_pos_reg;
        end else begin
            m_payload.kind           = KIND_MARKER;
            m_payload.out_byte       = '0;
            m_payload.match_position = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg           <= MODE_REPLACE_ALL;
            pattern_reg        <= '0;
            plen_cfg_reg       <= '0;
            repl_reg           <= '0;
            rlen_cfg_reg       <= '0;
            held_count_reg     <= '0;
            byte_pos_reg       <= '0;
            first_replaced_reg <= 1'b0;
            token_open_reg     <= 1'b0;
            res_count_reg      <= '0;
            res_idx_reg        <= '0;
        end else begin
            if (s_accept) begin
                held_count_reg     <= held_count_next;
                byte_pos_reg       <= byte_pos_next;
                first_replaced_reg <= first_replaced_next;
                token_open_reg     <= token_open_next;
                res_count_reg      <= res_count_next;
                res_idx_reg        <= '0;
            end else if (m_valid && m_ready) begin
                res_idx_reg <= res_idx_reg + RES_CNT_W'(1);
            end
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_MODE: begin
                        mode_reg       <= mode_t'(cfg_data[1:0]);
                        held_count_reg <= '0;
                    end
                    REG_PATTERN: begin
                        pattern_reg    <= cfg_data;
                        held_count_reg <= '0;
                    end
                    REG_PATTERN_LEN: begin
                        plen_cfg_reg   <= cfg_data[LEN_W-1:0];
                        held_count_reg <= '0;
                    end
                    REG_REPL: begin
                        repl_reg <= cfg_data;
                    end
                    REG_REPL_LEN: begin
                        rlen_cfg_reg <= cfg_data[LEN_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            held_reg      <= held_next;
            res_data_reg  <= res_data_next;
            res_ndata_reg <= res_ndata_next;
            res_tail_reg  <= res_tail_next;
            res_pos_reg   <= res_pos_next;
            res_eos_reg   <= eos;
        end
    end

endmodule
